FILE: src/i2ctrf_pkg.sv
// ---------------------------------------------------------------------------
// I2C target register file package
// Shared constants, the bus event codes and the memory request bundle.
// ---------------------------------------------------------------------------
package i2ctrf_pkg;

	localparam int REG_DEPTH = 256;
	localparam int REG_AW    = (REG_DEPTH > 1) ? $clog2(REG_DEPTH) : 1;
	localparam int PTR_W     = 8;
	localparam int BYTE_W    = 8;
	localparam int LIMIT_W   = 9;
	localparam int CNT_W     = 32;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(256);
	localparam logic [LIMIT_W-1:0] DEPTH_BOUND = LIMIT_W'(REG_DEPTH);
	localparam logic [BYTE_W-1:0]  TX_IDLE     = 8'hFF;

	typedef enum logic [2:0] {
		CMD_MATCH    = 3'd0,
		CMD_RECV     = 3'd1,
		CMD_READ     = 3'd2,
		CMD_NACK     = 3'd3,
		CMD_ARB_LOST = 3'd4,
		CMD_END      = 3'd5
	} cmd_t;

	typedef struct packed {
		logic              we;
		logic              re;
		logic [REG_AW-1:0] addr;
		logic [BYTE_W-1:0] wdata;
	} mem_req_t;

endpackage

FILE: src/i2ctrf_regmem.sv
// ---------------------------------------------------------------------------
// I2C target register file storage
// Byte memory with a synchronous read port and one valid bit per entry, so
// that an entry not written since reset reads back as zero.
// ---------------------------------------------------------------------------
module i2ctrf_regmem (
	input  logic                     clk,
	input  logic                     arst_n,
	input  i2ctrf_pkg::mem_req_t     req,
	output logic [i2ctrf_pkg::BYTE_W-1:0] rdata
);
	import i2ctrf_pkg::*;

	logic [BYTE_W-1:0]    mem [REG_DEPTH];
	logic [REG_DEPTH-1:0] vld_q;
	logic [BYTE_W-1:0]    mem_rd_q;
	logic                 vld_rd_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.addr] <= req.wdata;
		end
		if (req.re) begin
			mem_rd_q <= mem[req.addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			vld_rd_q <= 1'b0;
		end else begin
			if (req.we) begin
				vld_q[req.addr] <= 1'b1;
			end
			if (req.re) begin
				vld_rd_q <= vld_q[req.addr];
			end
		end
	end

	assign rdata = vld_rd_q ? mem_rd_q : '0;

endmodule

FILE: src/i2c_target_register_file.sv
// ---------------------------------------------------------------------------
// I2C target register file
// Byte register target with an auto-incrementing pointer and event counters.
// ---------------------------------------------------------------------------
// One bus event is taken per word and gives one result word. At the
// accepting edge the event updates the pointer, flags and counters, and
// the synchronous read port of the register memory captures its byte.
// Both are loaded into the output register once it is free or its result
// is taken. Events may be accepted in every cycle, so the sustained rate
// is one event per cycle while the output side takes results. A result
// held by the output stall, with another word waiting in stage one, blocks
// the input until it leaves. Registers not written since reset read as
// zero through per-entry valid bits, so the block is ready straight out
// of reset with no clearing pass.
module i2c_target_register_file (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [i2ctrf_pkg::LIMIT_W-1:0]     cfg_data,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [2:0]                         cmd,
	input  logic [i2ctrf_pkg::BYTE_W-1:0]      data,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [i2ctrf_pkg::BYTE_W-1:0]      tx_data,
	output logic                               busy_res,
	output logic [i2ctrf_pkg::PTR_W-1:0]       pointer_now,
	output logic [i2ctrf_pkg::CNT_W-1:0]       match_count,
	output logic [i2ctrf_pkg::CNT_W-1:0]       received_count,
	output logic [i2ctrf_pkg::CNT_W-1:0]       sent_count,
	output logic [i2ctrf_pkg::CNT_W-1:0]       nack_count
);
	import i2ctrf_pkg::*;

	logic [LIMIT_W-1:0] limit_q;
	logic [PTR_W-1:0]   ptr_q, ptr_d;
	logic               expect_q, expect_d;
	logic               busy_q, busy_d;
	logic [CNT_W-1:0]   match_q, match_d;
	logic [CNT_W-1:0]   recv_q, recv_d;
	logic [CNT_W-1:0]   sent_q, sent_d;
	logic [CNT_W-1:0]   nack_q, nack_d;

	logic               valid_s1;
	logic               use_mem_s1;

	logic               out_valid_q;
	logic [BYTE_W-1:0]  tx_q;
	logic               busy_out_q;
	logic [PTR_W-1:0]   ptr_out_q;
	logic [CNT_W-1:0]   match_out_q, recv_out_q, sent_out_q, nack_out_q;

	logic               accept;
	logic               load_out;
	logic               ptr_in_mem;
	logic               ptr_in_lim;
	cmd_t               cmd_e;
	mem_req_t           req;
	logic [BYTE_W-1:0]  rdata;

	assign cmd_e      = cmd_t'(cmd);
	assign load_out   = valid_s1 & (~out_valid_q | ~out_stall);
	assign in_stall   = valid_s1 & ~load_out;
	assign accept     = in_valid & ~in_stall;
	assign ptr_in_mem = {1'b0, ptr_q} < DEPTH_BOUND;
	assign ptr_in_lim = {1'b0, ptr_q} < limit_q;

	always_comb begin
		ptr_d    = ptr_q;
		expect_d = expect_q;
		busy_d   = busy_q;
		match_d  = match_q;
		recv_d   = recv_q;
		sent_d   = sent_q;
		nack_d   = nack_q;
		req      = '0;
		req.addr = ptr_q[REG_AW-1:0];
		req.wdata = data;
		unique case (cmd_e)
			CMD_MATCH: begin
				match_d  = match_q + CNT_W'(1);
				busy_d   = 1'b1;
				expect_d = 1'b1;
			end
			CMD_RECV: begin
				recv_d = recv_q + CNT_W'(1);
				if (expect_q) begin
					ptr_d    = data;
					expect_d = 1'b0;
				end else begin
					req.we = ptr_in_mem;
					ptr_d  = ptr_q + PTR_W'(1);
				end
			end
			CMD_READ: begin
				req.re = ptr_in_mem & ptr_in_lim;
				sent_d = sent_q + CNT_W'(1);
				ptr_d  = ptr_q + PTR_W'(1);
			end
			CMD_NACK: begin
				nack_d   = nack_q + CNT_W'(1);
				busy_d   = 1'b0;
				expect_d = 1'b1;
			end
			CMD_ARB_LOST, CMD_END: begin
				busy_d   = 1'b0;
				expect_d = 1'b1;
			end
			default: begin
			end
		endcase
		// Nothing reaches the memory unless the event is actually taken.
		req.we = req.we & accept;
		req.re = req.re & accept;
	end

	i2ctrf_regmem u_regmem (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rdata  (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q     <= LIMIT_RESET;
			ptr_q       <= '0;
			expect_q    <= 1'b1;
			busy_q      <= 1'b0;
			match_q     <= '0;
			recv_q      <= '0;
			sent_q      <= '0;
			nack_q      <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				limit_q <= cfg_data;
			end
			if (accept) begin
				ptr_q    <= ptr_d;
				expect_q <= expect_d;
				busy_q   <= busy_d;
				match_q  <= match_d;
				recv_q   <= recv_d;
				sent_q   <= sent_d;
				nack_q   <= nack_d;
			end
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (load_out) begin
				valid_s1 <= 1'b0;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			use_mem_s1 <= req.re;
		end
		// The state registers still hold the outcome of the word in stage one
		// here, since any newly accepted word only updates them at this edge.
		if (load_out) begin
			tx_q        <= use_mem_s1 ? rdata : TX_IDLE;
			busy_out_q  <= busy_q;
			ptr_out_q   <= ptr_q;
			match_out_q <= match_q;
			recv_out_q  <= recv_q;
			sent_out_q  <= sent_q;
			nack_out_q  <= nack_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign tx_data        = tx_q;
	assign busy_res       = busy_out_q;
	assign pointer_now    = ptr_out_q;
	assign match_count    = match_out_q;
	assign received_count = recv_out_q;
	assign sent_count     = sent_out_q;
	assign nack_count     = nack_out_q;

endmodule

FILE: src/i2ctrf_checker.sv
// ---------------------------------------------------------------------------
// I2C target register file checker
// Port-level properties of the register file, bound to the top level.
// ---------------------------------------------------------------------------
module i2ctrf_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [i2ctrf_pkg::LIMIT_W-1:0]     cfg_data,
	input  logic                               in_valid,
	input  logic                               in_stall,
	input  logic [2:0]                         cmd,
	input  logic [i2ctrf_pkg::BYTE_W-1:0]      data,
	input  logic                               out_valid,
	input  logic                               out_stall,
	input  logic [i2ctrf_pkg::BYTE_W-1:0]      tx_data,
	input  logic                               busy_res,
	input  logic [i2ctrf_pkg::PTR_W-1:0]       pointer_now,
	input  logic [i2ctrf_pkg::CNT_W-1:0]       match_count,
	input  logic [i2ctrf_pkg::CNT_W-1:0]       received_count,
	input  logic [i2ctrf_pkg::CNT_W-1:0]       sent_count,
	input  logic [i2ctrf_pkg::CNT_W-1:0]       nack_count
);
	import i2ctrf_pkg::*;

	// A stalled result must stay on the port unchanged.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(tx_data) &&
			$stable(pointer_now) && $stable(busy_res))
		else $error("stalled result changed");

	// The input side is only held off while a result is waiting downstream.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a blocked result");

	// A fresh result after an idle output must trace back to an accepted word.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall, 2))
		else $error("result appeared without an accepted word");

	// Successive results differ by at most one event in the match and NACK counters.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && $past(out_valid) |->
			(match_count == $past(match_count) ||
				match_count == $past(match_count) + CNT_W'(1)) &&
			(nack_count == $past(nack_count) ||
				nack_count == $past(nack_count) + CNT_W'(1)))
		else $error("counter jumped between results");

endmodule

bind i2c_target_register_file i2ctrf_checker u_i2ctrf_checker (.*);

FILE: tb/i2c_target_register_file_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// I2C target register file checker
// Watches both word channels and the limit register port, keeps its own
// model of the register file, pointer, flags and counters, and compares
// every result word field by field with the oldest prediction.
// ---------------------------------------------------------------------------
module i2c_target_register_file_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [i2ctrf_pkg::LIMIT_W-1:0] cfg_data,
	input  logic                           in_valid,
	input  logic                           in_stall,
	input  logic [2:0]                     cmd,
	input  logic [i2ctrf_pkg::BYTE_W-1:0]  data,
	input  logic                           out_valid,
	input  logic                           out_stall,
	input  logic [i2ctrf_pkg::BYTE_W-1:0]  tx_data,
	input  logic                           busy_res,
	input  logic [i2ctrf_pkg::PTR_W-1:0]   pointer_now,
	input  logic [i2ctrf_pkg::CNT_W-1:0]   match_count,
	input  logic [i2ctrf_pkg::CNT_W-1:0]   received_count,
	input  logic [i2ctrf_pkg::CNT_W-1:0]   sent_count,
	input  logic [i2ctrf_pkg::CNT_W-1:0]   nack_count,
	output int                             mismatches,
	output int                             pending_words
);
	import i2ctrf_pkg::*;

	typedef struct {
		logic [BYTE_W-1:0] tx;
		logic              busy;
		logic [PTR_W-1:0]  ptr;
		logic [CNT_W-1:0]  match_cnt;
		logic [CNT_W-1:0]  rx_bytes;
		logic [CNT_W-1:0]  tx_bytes;
		logic [CNT_W-1:0]  nacks;
	} bus_result_t;

	logic [BYTE_W-1:0]  reg_bytes [REG_DEPTH];
	logic [PTR_W-1:0]   reg_ptr;
	logic               want_ptr;
	logic               busy_q;
	logic [CNT_W-1:0]   n_match;
	logic [CNT_W-1:0]   n_rx;
	logic [CNT_W-1:0]   n_tx;
	logic [CNT_W-1:0]   n_nack;
	logic [LIMIT_W-1:0] read_limit_q;
	bus_result_t        result_q [$];

	initial begin
		mismatches = 0;
		pending_words = 0;
	end

	// Applies one bus event to the model and returns the word it should give.
	function automatic bus_result_t apply_event(logic [2:0] c, logic [BYTE_W-1:0] d);
		bus_result_t r;
		r.tx = TX_IDLE;
		case (c)
			CMD_MATCH: begin
				n_match  = n_match + 1'b1;
				busy_q   = 1'b1;
				want_ptr = 1'b1;
			end
			CMD_RECV: begin
				n_rx = n_rx + 1'b1;
				if (want_ptr) begin
					reg_ptr  = d;
					want_ptr = 1'b0;
				end else begin
					if (int'(reg_ptr) < REG_DEPTH)
						reg_bytes[reg_ptr] = d;
					reg_ptr = reg_ptr + 1'b1;
				end
			end
			CMD_READ: begin
				// Limits above 256 can never be reached by an 8-bit pointer.
				if ({1'b0, reg_ptr} < read_limit_q && int'(reg_ptr) < REG_DEPTH)
					r.tx = reg_bytes[reg_ptr];
				n_tx    = n_tx + 1'b1;
				reg_ptr = reg_ptr + 1'b1;
			end
			CMD_NACK: begin
				n_nack   = n_nack + 1'b1;
				busy_q   = 1'b0;
				want_ptr = 1'b1;
			end
			CMD_ARB_LOST, CMD_END: begin
				busy_q   = 1'b0;
				want_ptr = 1'b1;
			end
			default: ;
		endcase
		r.busy      = busy_q;
		r.ptr       = reg_ptr;
		r.match_cnt = n_match;
		r.rx_bytes  = n_rx;
		r.tx_bytes  = n_tx;
		r.nacks     = n_nack;
		return r;
	endfunction

	function automatic void check_field(string name, logic [CNT_W-1:0] want,
			logic [CNT_W-1:0] got);
		if (want !== got) begin
			mismatches = mismatches + 1;
			if (mismatches <= 10)
				$display("%0t: %s mismatch, expected %0h, got %0h", $realtime, name, want, got);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < REG_DEPTH; i++)
				reg_bytes[i] = '0;
			reg_ptr       = '0;
			want_ptr      = 1'b1;
			busy_q        = 1'b0;
			n_match       = '0;
			n_rx          = '0;
			n_tx          = '0;
			n_nack        = '0;
			read_limit_q  = LIMIT_RESET;
			result_q.delete();
			pending_words = 0;
		end else begin
			bus_result_t want;
			if (cfg_we === 1'b1)
				read_limit_q = cfg_data;
			if (out_valid === 1'b1 && out_stall === 1'b0) begin
				if (result_q.size() == 0) begin
					mismatches = mismatches + 1;
					if (mismatches <= 10)
						$display("%0t: result word arrived with none expected", $realtime);
				end else begin
					want = result_q.pop_front();
					check_field("tx_data", CNT_W'(want.tx), CNT_W'(tx_data));
					check_field("busy_res", CNT_W'(want.busy), CNT_W'(busy_res));
					check_field("pointer_now", CNT_W'(want.ptr), CNT_W'(pointer_now));
					check_field("match_count", want.match_cnt, match_count);
					check_field("received_count", want.rx_bytes, received_count);
					check_field("sent_count", want.tx_bytes, sent_count);
					check_field("nack_count", want.nacks, nack_count);
				end
			end
			if (in_valid === 1'b1 && in_stall === 1'b0)
				result_q.push_back(apply_event(cmd, data));
			pending_words = result_q.size();
		end
	end

endmodule

FILE: tb/i2c_target_register_file_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// I2C target register file testbench
// Drives bus events into the target, directed first and then as random
// transactions under several read limits, with random gaps and back-pressure.
// The checker alongside predicts and compares every result word.
// ---------------------------------------------------------------------------
module i2c_target_register_file_tb;
	import i2ctrf_pkg::*;

	// Codes the block must treat as no operation.
	localparam logic [2:0] CMD_SPARE_A = 3'd6;
	localparam logic [2:0] CMD_SPARE_B = 3'd7;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 cfg_we    = 1'b0;
	logic [LIMIT_W-1:0]   cfg_data  = '0;
	logic                 in_valid  = 1'b0;
	logic                 in_stall;
	logic [2:0]           cmd       = CMD_MATCH;
	logic [BYTE_W-1:0]    data      = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [BYTE_W-1:0]    tx_data;
	logic                 busy_res;
	logic [PTR_W-1:0]     pointer_now;
	logic [CNT_W-1:0]     match_count;
	logic [CNT_W-1:0]     received_count;
	logic [CNT_W-1:0]     sent_count;
	logic [CNT_W-1:0]     nack_count;

	int                   mismatches;
	int                   pending_words;
	int                   words_sent = 0;
	int                   limit_now  = 256;
	bit                   eager      = 1'b0;
	int                   stall_left = 0;
	logic                 stall_on   = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	i2c_target_register_file u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.cmd            (cmd),
		.data           (data),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.tx_data        (tx_data),
		.busy_res       (busy_res),
		.pointer_now    (pointer_now),
		.match_count    (match_count),
		.received_count (received_count),
		.sent_count     (sent_count),
		.nack_count     (nack_count)
	);

	i2c_target_register_file_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.cmd            (cmd),
		.data           (data),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.tx_data        (tx_data),
		.busy_res       (busy_res),
		.pointer_now    (pointer_now),
		.match_count    (match_count),
		.received_count (received_count),
		.sent_count     (sent_count),
		.nack_count     (nack_count),
		.mismatches     (mismatches),
		.pending_words  (pending_words)
	);

	// Result side back-pressure: mostly free-running stretches, some short
	// stalls and the occasional long one.
	always @(negedge clk) begin
		if (stall_left == 0) begin
			int roll;
			roll = $urandom_range(0, 99);
			if (roll < 70) begin
				stall_on   = 1'b0;
				stall_left = $urandom_range(1, 20);
			end else if (roll < 95) begin
				stall_on   = 1'b1;
				stall_left = $urandom_range(1, 3);
			end else begin
				stall_on   = 1'b1;
				stall_left = $urandom_range(10, 40);
			end
		end
		stall_left = stall_left - 1;
		out_stall <= stall_on;
	end

	task automatic send_word(input logic [2:0] c, input logic [BYTE_W-1:0] d);
		int gap;
		int roll;
		roll = $urandom_range(0, 99);
		if (eager || roll < 65)
			gap = 0;
		else if (roll < 92)
			gap = $urandom_range(1, 3);
		else
			gap = $urandom_range(8, 30);
		repeat (gap) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		cmd      <= c;
		data     <= d;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		if (c <= CMD_END)
			words_sent = words_sent + 1;
	endtask

	// Waits until every predicted word has come out, then lets the pipeline settle.
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_words != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_limit(input int v);
		drain();
		cfg_we    <= 1'b1;
		cfg_data  <= LIMIT_W'(v);
		limit_now = v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Pointers anywhere, near the 8-bit wrap, or around the read limit.
	function automatic logic [PTR_W-1:0] pick_pointer();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 45)
			return PTR_W'($urandom_range(0, 255));
		else if (roll < 70)
			return PTR_W'($urandom_range(248, 255));
		return PTR_W'(limit_now + $urandom_range(0, 7) - 4);
	endfunction

	task automatic run_traffic(input int n);
		int target;
		int roll;
		int len;
		int term;
		target = words_sent + n;
		while (words_sent < target) begin
			roll  = $urandom_range(0, 99);
			len   = $urandom_range(1, 8);
			eager = ($urandom_range(0, 4) == 0);
			if (roll < 10) begin
				send_word(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
			end else if (roll < 50) begin
				// Register write: address, pointer byte, data bytes.
				send_word(CMD_MATCH, 8'($urandom_range(0, 255)));
				send_word(CMD_RECV, pick_pointer());
				repeat (len) send_word(CMD_RECV, 8'($urandom_range(0, 255)));
				term = $urandom_range(0, 9);
				if (term < 5)
					send_word(CMD_END, 8'($urandom_range(0, 255)));
				else if (term < 7)
					send_word(CMD_NACK, 8'($urandom_range(0, 255)));
				else if (term < 9)
					send_word(CMD_ARB_LOST, 8'($urandom_range(0, 255)));
			end else if (roll < 90) begin
				// Combined read: pointer write, repeated start, reads, then a final NACK and end or a lost arbitration.
				send_word(CMD_MATCH, 8'($urandom_range(0, 255)));
				send_word(CMD_RECV, pick_pointer());
				send_word(CMD_MATCH, 8'($urandom_range(0, 255)));
				repeat (len) send_word(CMD_READ, 8'($urandom_range(0, 255)));
				if ($urandom_range(0, 4) != 0) begin
					send_word(CMD_NACK, 8'($urandom_range(0, 255)));
					send_word(CMD_END, 8'($urandom_range(0, 255)));
				end else begin
					send_word(CMD_ARB_LOST, 8'($urandom_range(0, 255)));
				end
			end else begin
				send_word(CMD_MATCH, 8'($urandom_range(0, 255)));
				repeat (len) send_word(3'($urandom_range(1, 7)), 8'($urandom_range(0, 255)));
			end
		end
		eager = 1'b0;
	endtask

	initial begin
		int plan [6];
		plan = '{0, 511, 1, 255, 256, 257};
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		// Directed part under the reset limit: reads and writes outside a
		// transaction, pointer wrap at both ends, restart reads and every end event.
		send_word(CMD_READ, 8'h00);
		send_word(CMD_RECV, 8'hAB);
		send_word(CMD_MATCH, 8'hFF);
		send_word(CMD_RECV, 8'hFF);
		send_word(CMD_RECV, 8'h00);
		send_word(CMD_RECV, 8'hFF);
		send_word(CMD_RECV, 8'h5A);
		send_word(CMD_END, 8'h00);
		send_word(CMD_MATCH, 8'h00);
		send_word(CMD_RECV, 8'hFE);
		send_word(CMD_MATCH, 8'h00);
		send_word(CMD_READ, 8'hFF);
		send_word(CMD_READ, 8'h00);
		send_word(CMD_READ, 8'h00);
		send_word(CMD_READ, 8'h00);
		send_word(CMD_NACK, 8'h00);
		send_word(CMD_ARB_LOST, 8'hFF);
		send_word(CMD_SPARE_A, 8'h00);
		send_word(CMD_SPARE_B, 8'hFF);
		send_word(CMD_END, 8'h00);
		send_word(CMD_READ, 8'h00);

		// Limit of zero: everything reads back idle, then the fixed and random limits.
		for (int phase = 0; phase < 9; phase++) begin
			write_limit(phase < 6 ? plan[phase] : $urandom_range(0, 511));
			if (phase == 0) begin
				send_word(CMD_MATCH, 8'h00);
				send_word(CMD_RECV, 8'h00);
				send_word(CMD_MATCH, 8'h00);
				send_word(CMD_READ, 8'h00);
				send_word(CMD_READ, 8'h00);
			end
			run_traffic(145);
		end

		drain();
		repeat (8) @(negedge clk);
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin
		#(5_000_000);
		$display("TEST FAILED");
		$finish;
	end

endmodule
